[rtl/blm_pkg.sv]
// ----------------------------------------------------------------------------
// blm_pkg: shared types and constants of the battery level monitor
// Field widths, register indexes and reset values, level codes, the
// configuration bundle and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package blm_pkg;

  // Parameter defaults
  localparam int VOLT_WIDTH_DEF  = 14;
  localparam int MAX_SAMPLES_DEF = 64;

  // Fixed field widths
  localparam int FIELD_W    = 14;
  localparam int COUNT_W    = 7;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 14;

  // Smallest usable sample count (min and max are dropped)
  localparam int MIN_COUNT = 3;

  // Hysteresis offsets around the plenty/mid threshold, in mV
  localparam int OFS_MID_TO_PLENTY = 250;
  localparam int OFS_MID_TO_LOW    = 200;
  localparam int OFS_LOW_TO_MID    = 50;

  // Register reset values
  localparam logic [COUNT_W-1:0] RST_SAMPLE_COUNT = 7'd8;
  localparam logic [FIELD_W-1:0] RST_NORMAL_THR   = 14'd3650;
  localparam logic [FIELD_W-1:0] RST_TURBO_THR    = 14'd3550;
  localparam logic [FIELD_W-1:0] RST_VLOW_ENTER   = 14'd2950;
  localparam logic [FIELD_W-1:0] RST_VLOW_EXIT    = 14'd3300;
  localparam logic [FIELD_W-1:0] RST_FAULT_LEVEL  = 14'd2750;

  // Register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_NORMAL_THR   = 3'd1,
    REG_TURBO_THR    = 3'd2,
    REG_VLOW_ENTER   = 3'd3,
    REG_VLOW_EXIT    = 3'd4,
    REG_FAULT_LEVEL  = 3'd5
  } reg_idx_t;

  // Battery level codes
  typedef enum logic [1:0] {
    LVL_PLENTY = 2'd0,
    LVL_MID    = 2'd1,
    LVL_LOW    = 2'd2,
    LVL_VLOW   = 2'd3
  } level_t;

  // Configuration registers
  typedef struct packed {
    logic [COUNT_W-1:0] sample_count;
    logic [FIELD_W-1:0] normal_thr;
    logic [FIELD_W-1:0] turbo_thr;
    logic [FIELD_W-1:0] vlow_enter;
    logic [FIELD_W-1:0] vlow_exit;
    logic [FIELD_W-1:0] fault_level;
  } cfg_t;

  // One result record
  typedef struct packed {
    level_t             level;
    logic [FIELD_W-1:0] filtered_mv;
    logic               low_alert;
    logic               low_fault;
    logic               average_updated;
  } result_t;

endpackage

`default_nettype wire

[rtl/blm_front.sv]
// ----------------------------------------------------------------------------
// blm_front: sample accumulator
// Takes samples, keeps sum/min/max and count, and decides per item whether
// it accumulates or closes an average; pushes one job per item to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_front #(
  parameter int VOLT_WIDTH  = blm_pkg::VOLT_WIDTH_DEF,
  parameter int MAX_SAMPLES = blm_pkg::MAX_SAMPLES_DEF,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
  parameter int SUM_W       = VOLT_WIDTH + CNT_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [blm_pkg::COUNT_W-1:0]   cfg_sample_count,
  input  wire logic                          in_push,
  input  wire logic [blm_pkg::FIELD_W-1:0]   in_voltage_mv,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic                               q_update,
  output logic [SUM_W-1:0]                   q_trimmed,
  output logic [CNT_W-1:0]                   q_divisor
);

  localparam int CW = (CNT_W > blm_pkg::COUNT_W) ? CNT_W : blm_pkg::COUNT_W;
  localparam int NB = (VOLT_WIDTH < blm_pkg::FIELD_W) ? VOLT_WIDTH : blm_pkg::FIELD_W;

  logic [CNT_W-1:0]      cnt_r;
  logic [SUM_W-1:0]      sum_r;
  logic [VOLT_WIDTH-1:0] min_r;
  logic [VOLT_WIDTH-1:0] max_r;

  logic [VOLT_WIDTH-1:0] volt;
  logic [CW-1:0]         cfg_ext;
  logic [CW-1:0]         eff;
  logic                  accumulate;
  logic                  accept;

  // Sample masked to the internal voltage width
  always_comb begin
    volt = '0;
    for (int i = 0; i < NB; i++) begin
      volt[i] = in_voltage_mv[i];
    end
  end

  // Clamp the configured count into the usable range
  always_comb begin
    cfg_ext = CW'(cfg_sample_count);
    if (cfg_ext > CW'(MAX_SAMPLES)) begin
      eff = CW'(MAX_SAMPLES);
    end else if (cfg_ext < CW'(blm_pkg::MIN_COUNT)) begin
      eff = CW'(blm_pkg::MIN_COUNT);
    end else begin
      eff = cfg_ext;
    end
  end

  assign accumulate = CW'(cnt_r) < eff;
  assign accept     = in_push && !q_full;

  // Job to the back end
  assign q_push    = accept;
  assign q_update  = !accumulate;
  assign q_trimmed = sum_r - SUM_W'(min_r) - SUM_W'(max_r);
  assign q_divisor = cnt_r - CNT_W'(2);

  // Accumulator; an averaging item restarts it and drops its own sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      sum_r <= '0;
      min_r <= '1;
      max_r <= '0;
    end else if (accept) begin
      if (accumulate) begin
        cnt_r <= cnt_r + CNT_W'(1);
        sum_r <= sum_r + SUM_W'(volt);
        if (volt < min_r) begin
          min_r <= volt;
        end
        if (volt > max_r) begin
          max_r <= volt;
        end
      end else begin
        cnt_r <= '0;
        sum_r <= '0;
        min_r <= '1;
        max_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/blm_fifo.sv]
// ----------------------------------------------------------------------------
// blm_fifo: short job queue
// Register-based FIFO between the accumulator and the evaluation engine.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic                   full,
  input  wire logic              pop,
  output logic [DATA_W-1:0]      rd_data,
  output logic                   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full    = count_r == CNT_W'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/blm_back.sv]
// ----------------------------------------------------------------------------
// blm_back: evaluation engine
// Runs the bit-serial divide for averaging jobs, then derives alert and
// fault flags, steps the level hysteresis and fills the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module blm_back #(
  parameter int VOLT_WIDTH  = blm_pkg::VOLT_WIDTH_DEF,
  parameter int MAX_SAMPLES = blm_pkg::MAX_SAMPLES_DEF,
  parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
  parameter int SUM_W       = VOLT_WIDTH + CNT_W
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire blm_pkg::cfg_t               cfg,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  input  wire logic                        q_update,
  input  wire logic                        q_turbo,
  input  wire logic [blm_pkg::FIELD_W-1:0] q_alert_thr,
  input  wire logic [SUM_W-1:0]            q_trimmed,
  input  wire logic [CNT_W-1:0]            q_divisor,
  input  wire logic                        out_pop,
  output logic                             out_empty,
  output blm_pkg::result_t                 result,
  output blm_pkg::level_t                  level
);

  localparam int BIT_W = $clog2(SUM_W + 1);
  localparam int EW    = ((VOLT_WIDTH > blm_pkg::FIELD_W) ? VOLT_WIDTH : blm_pkg::FIELD_W) + 2;
  localparam int NB    = (VOLT_WIDTH < blm_pkg::FIELD_W) ? VOLT_WIDTH : blm_pkg::FIELD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EVAL
  } state_t;

  state_t                        state_r;
  logic                          turbo_r;
  logic                          upd_r;
  logic [blm_pkg::FIELD_W-1:0]   alert_thr_r;
  logic [CNT_W-1:0]              rem_r;
  logic [SUM_W-1:0]              quo_r;
  logic [CNT_W-1:0]              div_r;
  logic [BIT_W-1:0]              bit_cnt_r;
  logic [VOLT_WIDTH-1:0]         cell_r;
  blm_pkg::level_t               level_r;
  blm_pkg::result_t              res_r;
  logic                          res_valid_r;

  logic                          take;
  logic [CNT_W:0]                rem_sh;
  logic                          ge;
  logic [CNT_W-1:0]              rem_nxt;
  logic [SUM_W-1:0]              quo_nxt;
  logic signed [EW-1:0]          v_s;
  logic signed [EW-1:0]          t_s;
  logic                          fault;
  logic                          alert;
  blm_pkg::level_t               level_nxt;
  logic [blm_pkg::FIELD_W-1:0]   filtered;

  // Start a job only when the result slot is free by the time it finishes
  assign take  = (state_r == ST_IDLE) && !q_empty && (!res_valid_r || out_pop);
  assign q_pop = take;

  // One restoring divide step; the remainder stays below the divisor
  always_comb begin
    rem_sh  = {rem_r, quo_r[SUM_W-1]};
    ge      = rem_sh >= {1'b0, div_r};
    rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, div_r}) : rem_sh[CNT_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], ge};
  end

  // Flags from the filtered voltage
  always_comb begin
    v_s   = signed'(EW'(cell_r));
    t_s   = signed'(EW'(turbo_r ? cfg.turbo_thr : cfg.normal_thr));
    fault = v_s <= signed'(EW'(cfg.fault_level));
    alert = !fault && (v_s <= signed'(EW'(alert_thr_r)));
  end

  // Level hysteresis; the later check wins where both hold
  always_comb begin
    level_nxt = level_r;
    unique case (level_r)
      blm_pkg::LVL_PLENTY: begin
        if (v_s < t_s) level_nxt = blm_pkg::LVL_MID;
      end
      blm_pkg::LVL_MID: begin
        if (v_s > t_s + EW'(blm_pkg::OFS_MID_TO_PLENTY)) level_nxt = blm_pkg::LVL_PLENTY;
        if (v_s < t_s - EW'(blm_pkg::OFS_MID_TO_LOW)) level_nxt = blm_pkg::LVL_LOW;
      end
      blm_pkg::LVL_LOW: begin
        if (v_s > t_s + EW'(blm_pkg::OFS_LOW_TO_MID)) level_nxt = blm_pkg::LVL_MID;
        if (v_s < signed'(EW'(cfg.vlow_enter))) level_nxt = blm_pkg::LVL_VLOW;
      end
      blm_pkg::LVL_VLOW: begin
        if (v_s > signed'(EW'(cfg.vlow_exit))) level_nxt = blm_pkg::LVL_LOW;
      end
      default: level_nxt = level_r;
    endcase
  end

  // Filtered voltage onto the 14-bit result field
  always_comb begin
    filtered = '0;
    for (int i = 0; i < NB; i++) begin
      filtered[i] = cell_r[i];
    end
  end

  // Sequencer, divider and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      res_valid_r <= 1'b0;
      level_r     <= blm_pkg::LVL_PLENTY;
      cell_r      <= '0;
    end else begin
      if (out_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            turbo_r     <= q_turbo;
            alert_thr_r <= q_alert_thr;
            upd_r       <= q_update;
            quo_r       <= q_trimmed;
            rem_r       <= '0;
            div_r       <= q_divisor;
            bit_cnt_r   <= BIT_W'(SUM_W);
            state_r     <= q_update ? ST_DIV : ST_EVAL;
          end
        end
        ST_DIV: begin
          rem_r     <= rem_nxt;
          quo_r     <= quo_nxt;
          bit_cnt_r <= bit_cnt_r - BIT_W'(1);
          if (bit_cnt_r == BIT_W'(1)) begin
            cell_r  <= quo_nxt[VOLT_WIDTH-1:0];
            state_r <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          level_r               <= level_nxt;
          res_r.level           <= level_nxt;
          res_r.filtered_mv     <= filtered;
          res_r.low_alert       <= alert;
          res_r.low_fault       <= fault;
          res_r.average_updated <= upd_r;
          res_valid_r           <= 1'b1;
          state_r               <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_empty = !res_valid_r;
  assign result    = res_r;
  assign level     = level_r;

endmodule

`default_nettype wire

[rtl/battery_level_monitor.sv]
// ----------------------------------------------------------------------------
// battery_level_monitor: trimmed-mean battery level with hysteresis
// Accumulates cell-voltage samples, takes a trimmed average on the item after
// each sample_count samples and reports alert, fault and a four-level status.
// ----------------------------------------------------------------------------
//  Channel  Ports                        Transfer when
//  input    in_push / in_full            in_push && !in_full
//  result   out_pop / out_empty          out_pop && !out_empty
//  config   cfg_we / cfg_addr / cfg_wdata cfg_we
//
//  A sampling item goes from idle straight to evaluation in the evaluation
//  engine; an averaging item first passes the one-bit-per-cycle restoring
//  divider over all SUM_W quotient bits. The accumulator takes a new item
//  each cycle while the two-entry job queue has room.
//  Reset is synchronous and active low; no clearing pass is needed.
//  A held result stalls the engine, and input once the job queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_monitor #(
  parameter int VOLT_WIDTH  = blm_pkg::VOLT_WIDTH_DEF,
  parameter int MAX_SAMPLES = blm_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire logic [blm_pkg::FIELD_W-1:0]    in_voltage_mv,
  input  wire logic                           in_turbo_mode,
  input  wire logic [blm_pkg::FIELD_W-1:0]    in_alert_threshold_mv,
  input  wire logic                           out_pop,
  output logic                                out_empty,
  output logic [1:0]                          out_battery_level,
  output logic [blm_pkg::FIELD_W-1:0]         out_filtered_mv,
  output logic                                out_low_alert,
  output logic                                out_low_fault,
  output logic                                out_average_updated,
  input  wire logic                           cfg_we,
  input  wire logic [blm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [blm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = VOLT_WIDTH + CNT_W;
  localparam int Q_W   = 2 + blm_pkg::FIELD_W + SUM_W + CNT_W;
  localparam int Q_DEPTH = 2;

  blm_pkg::cfg_t               cfg_r;
  logic                        q_push;
  logic                        q_full;
  logic                        q_pop;
  logic                        q_empty;
  logic                        f_update;
  logic [SUM_W-1:0]            f_trimmed;
  logic [CNT_W-1:0]            f_divisor;
  logic [Q_W-1:0]              q_wr_data;
  logic [Q_W-1:0]              q_rd_data;
  logic                        b_update;
  logic                        b_turbo;
  logic [blm_pkg::FIELD_W-1:0] b_alert_thr;
  logic [SUM_W-1:0]            b_trimmed;
  logic [CNT_W-1:0]            b_divisor;
  blm_pkg::result_t            result;
  blm_pkg::level_t             level;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_count <= blm_pkg::RST_SAMPLE_COUNT;
      cfg_r.normal_thr   <= blm_pkg::RST_NORMAL_THR;
      cfg_r.turbo_thr    <= blm_pkg::RST_TURBO_THR;
      cfg_r.vlow_enter   <= blm_pkg::RST_VLOW_ENTER;
      cfg_r.vlow_exit    <= blm_pkg::RST_VLOW_EXIT;
      cfg_r.fault_level  <= blm_pkg::RST_FAULT_LEVEL;
    end else if (cfg_we) begin
      unique case (blm_pkg::reg_idx_t'(cfg_addr))
        blm_pkg::REG_SAMPLE_COUNT: cfg_r.sample_count <= cfg_wdata[blm_pkg::COUNT_W-1:0];
        blm_pkg::REG_NORMAL_THR:   cfg_r.normal_thr   <= cfg_wdata;
        blm_pkg::REG_TURBO_THR:    cfg_r.turbo_thr    <= cfg_wdata;
        blm_pkg::REG_VLOW_ENTER:   cfg_r.vlow_enter   <= cfg_wdata;
        blm_pkg::REG_VLOW_EXIT:    cfg_r.vlow_exit    <= cfg_wdata;
        blm_pkg::REG_FAULT_LEVEL:  cfg_r.fault_level  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Accumulator
  blm_front #(
    .VOLT_WIDTH  (VOLT_WIDTH),
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_sample_count (cfg_r.sample_count),
    .in_push          (in_push),
    .in_voltage_mv    (in_voltage_mv),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_update         (f_update),
    .q_trimmed        (f_trimmed),
    .q_divisor        (f_divisor)
  );

  assign in_full   = q_full;
  assign q_wr_data = {f_update, in_turbo_mode, in_alert_threshold_mv, f_trimmed, f_divisor};

  // Job queue
  blm_fifo #(
    .DATA_W (Q_W),
    .DEPTH  (Q_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  assign {b_update, b_turbo, b_alert_thr, b_trimmed, b_divisor} = q_rd_data;

  // Evaluation engine
  blm_back #(
    .VOLT_WIDTH  (VOLT_WIDTH),
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_update    (b_update),
    .q_turbo     (b_turbo),
    .q_alert_thr (b_alert_thr),
    .q_trimmed   (b_trimmed),
    .q_divisor   (b_divisor),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .result      (result),
    .level       (level)
  );

  // Result ports
  assign out_battery_level   = result.level;
  assign out_filtered_mv     = result.filtered_mv;
  assign out_low_alert       = result.low_alert;
  assign out_low_fault       = result.low_fault;
  assign out_average_updated = result.average_updated;

`ifndef ASSERT_OFF
  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  // Alert and fault never show together
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_low_alert && out_low_fault))
    else $error("alert and fault both set");

  // Plenty only moves to mid
  a_plenty_step: assert property (@(posedge clk) disable iff (!rst_n)
    level == blm_pkg::LVL_PLENTY |=>
      (level == blm_pkg::LVL_PLENTY || level == blm_pkg::LVL_MID))
    else $error("level skipped from plenty");

  // Very low only moves to low
  a_vlow_step: assert property (@(posedge clk) disable iff (!rst_n)
    level == blm_pkg::LVL_VLOW |=>
      (level == blm_pkg::LVL_VLOW || level == blm_pkg::LVL_LOW))
    else $error("level skipped from very low");
`endif

endmodule

`default_nettype wire
